@@ rtl/core/pixel_decimate_premultiply_pack_top_macros.svh @@
// ----------------------------------------------------------------------------
// pixel decimate premultiply pack assertion macros
// Concurrent assertion wrappers used by the checker file pdpp_checker.
// ----------------------------------------------------------------------------
`ifndef PIXEL_DECIMATE_PREMULTIPLY_PACK_TOP_MACROS_SVH
`define PIXEL_DECIMATE_PREMULTIPLY_PACK_TOP_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define PDPP_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pdpp assertion failed");

// assertion on the block clock and reset
`define PDPP_ASSERT(lbl, prop) `PDPP_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

@@ rtl/core/pdpp_pkg.sv @@
// ----------------------------------------------------------------------------
// pdpp_pkg
// Shared types, register indexes, codes and the premultiply function.
// ----------------------------------------------------------------------------
package pdpp_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_DIM_W  = 13;
  localparam int unsigned CFG_SHIFT_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SHIFT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_ORDER    = 2'd3;

  // sample shift codes
  localparam logic [CFG_SHIFT_W-1:0] SHIFT_X1   = 2'd0;
  localparam logic [CFG_SHIFT_W-1:0] SHIFT_X2   = 2'd1;
  localparam logic [CFG_SHIFT_W-1:0] SHIFT_X4   = 2'd2;
  localparam logic [CFG_SHIFT_W-1:0] SHIFT_RSVD = 2'd3;

  // byte order codes
  localparam logic ORDER_RED_LOW   = 1'b0;
  localparam logic ORDER_ALPHA_LOW = 1'b1;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
  localparam logic [15:0] PREMUL_ROUND = 16'd128;

  // decision of the sample selector for one pixel
  typedef struct packed {
    logic keep;
    logic frame_done;
  } sel_t;

  // c * a / 255 with rounding, 16-bit intermediate
  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] s;
    p = ({8'd0, c} * {8'd0, a}) + PREMUL_ROUND;
    s = {1'b0, p} + {9'd0, p[15:8]};
    return s[15:8];
  endfunction

endpackage

@@ rtl/core/pdpp_pixel_if.sv @@
// ----------------------------------------------------------------------------
// pdpp_pixel_if
// Valid/ready channel carrying one RGBA source pixel per beat.
// ----------------------------------------------------------------------------
interface pdpp_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

@@ rtl/core/pdpp_result_if.sv @@
// ----------------------------------------------------------------------------
// pdpp_result_if
// Valid/ready channel carrying one packed output pixel per beat.
// ----------------------------------------------------------------------------
interface pdpp_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic        frame_done;

  modport source (output valid, pixel_word, frame_done, input ready);
  modport sink   (input valid, pixel_word, frame_done, output ready);
endinterface

@@ rtl/core/pdpp_pos_counter.sv @@
// ----------------------------------------------------------------------------
// pdpp_pos_counter
// Raster column and row counters, advanced once per accepted pixel beat.
// ----------------------------------------------------------------------------
module pdpp_pos_counter #(
  parameter int unsigned CW = 12,
  parameter int unsigned DW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  logic [DW-1:0] width_i,
  input  logic [DW-1:0] height_i,
  output logic [CW-1:0] col_o,
  output logic [CW-1:0] row_o,
  output logic          last_col_o,
  output logic          last_row_o
);

  localparam int unsigned PW = CW + 1;

  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] row_q, row_d;
  logic [PW-1:0] col_inc;
  logic [PW-1:0] row_inc;

  // end of row and end of frame detection
  assign col_inc    = {1'b0, col_q} + PW'(1);
  assign row_inc    = {1'b0, row_q} + PW'(1);
  assign last_col_o = col_inc >= PW'(width_i);
  assign last_row_o = row_inc >= PW'(height_i);

  // wrap column into next row, row into next frame
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (last_col_o) begin
        col_d = '0;
        row_d = last_row_o ? '0 : row_inc[CW-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o = col_q;
  assign row_o = row_q;

endmodule

@@ rtl/core/pdpp_sample_select.sv @@
// ----------------------------------------------------------------------------
// pdpp_sample_select
// Decides whether a pixel lies on the decimated grid and flags frame end.
// ----------------------------------------------------------------------------
module pdpp_sample_select #(
  parameter int unsigned CW = 12,
  parameter int unsigned DW = 13
) (
  input  logic [CW-1:0]                   col_i,
  input  logic [CW-1:0]                   row_i,
  input  logic                            last_col_i,
  input  logic                            last_row_i,
  input  logic [DW-1:0]                   width_i,
  input  logic [DW-1:0]                   height_i,
  input  logic [pdpp_pkg::CFG_SHIFT_W-1:0] shift_i,
  output pdpp_pkg::sel_t                  sel_o
);

  localparam int unsigned PW = (CW + 1 > DW) ? CW + 1 : DW;

  logic [DW-1:0] wo, ho;
  logic [CW-1:0] mask, half, colh;
  logic [PW-1:0] row_dec, col_dec;
  logic          row_on, col_on;

  always_comb begin
    // grid phase and spacing for the factor
    unique case (shift_i)
      pdpp_pkg::SHIFT_X1: begin
        mask = '0;
        half = '0;
      end
      pdpp_pkg::SHIFT_X2: begin
        mask = CW'(1);
        half = CW'(1);
      end
      default: begin
        mask = CW'(3);
        half = CW'(2);
      end
    endcase

    wo      = width_i >> shift_i;
    ho      = height_i >> shift_i;
    colh    = col_i - half;
    row_dec = PW'(row_i >> shift_i);
    col_dec = PW'(colh >> shift_i);

    row_on = ((row_i & mask) == '0) && (row_dec < PW'(ho));
    col_on = (col_i >= half) && ((colh & mask) == '0) && (col_dec < PW'(wo));

    // pass-through keeps every pixel, decimation keeps grid pixels only
    if (shift_i == pdpp_pkg::SHIFT_X1) begin
      sel_o.keep       = 1'b1;
      sel_o.frame_done = last_col_i && last_row_i;
    end else begin
      sel_o.keep       = (wo != '0) && (ho != '0) && row_on && col_on;
      sel_o.frame_done = (row_dec == PW'(ho - DW'(1))) && (col_dec == PW'(wo - DW'(1)));
    end
  end

endmodule

@@ rtl/core/pdpp_premul_pack.sv @@
// ----------------------------------------------------------------------------
// pdpp_premul_pack
// Alpha premultiply of the color channels and packing into a 32-bit word.
// ----------------------------------------------------------------------------
module pdpp_premul_pack (
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  input  logic        decimate_i,
  input  logic        order_i,
  output logic [31:0] word_o
);

  logic       do_premul;
  logic [7:0] r, g, b;

  // premultiply only translucent pixels when decimating
  assign do_premul = decimate_i && (alpha_i != pdpp_pkg::ALPHA_OPAQUE);
  assign r = do_premul ? pdpp_pkg::premul(red_i, alpha_i)   : red_i;
  assign g = do_premul ? pdpp_pkg::premul(green_i, alpha_i) : green_i;
  assign b = do_premul ? pdpp_pkg::premul(blue_i, alpha_i)  : blue_i;

  // byte order, pass-through always packs red low
  always_comb begin
    if (decimate_i && (order_i == pdpp_pkg::ORDER_ALPHA_LOW)) begin
      word_o = {r, g, b, alpha_i};
    end else begin
      word_o = {alpha_i, b, g, r};
    end
  end

endmodule

@@ rtl/core/pixel_decimate_premultiply_pack_top.sv @@
// An accepted input beat passes the input stage, then the output register.
// Throughput: one pixel per clock; ready drops only while a kept pixel waits
// behind a result beat that is stalled at the output register.
// Dropped pixels leave the input stage at once and never block the input.
// Reset (rst_ni low, async) clears counters and valid flags and sets the
// registers to width 1, height 1, factor 1, red-low byte order.
// ----------------------------------------------------------------------------
// pixel_decimate_premultiply_pack_top
// Nearest-neighbor decimation of an RGBA raster stream with alpha
// premultiply and selectable byte order packing.
// ----------------------------------------------------------------------------
module pixel_decimate_premultiply_pack_top #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pdpp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pdpp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  pdpp_pixel_if.sink                        in_px,
  pdpp_result_if.source                     out_px
);

  localparam int unsigned CW   = $clog2(MAX_DIMENSION);
  localparam int unsigned DW   = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned CMPW = (DW > pdpp_pkg::CFG_DIM_W) ? DW : pdpp_pkg::CFG_DIM_W;

  // configuration registers
  logic [pdpp_pkg::CFG_DIM_W-1:0]   width_q, height_q;
  logic [pdpp_pkg::CFG_SHIFT_W-1:0] shift_q;
  logic                             order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pdpp_pkg::CFG_DIM_W'(1);
      height_q <= pdpp_pkg::CFG_DIM_W'(1);
      shift_q  <= pdpp_pkg::SHIFT_X1;
      order_q  <= pdpp_pkg::ORDER_RED_LOW;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pdpp_pkg::REG_SOURCE_WIDTH:  width_q  <= cfg_data_i[pdpp_pkg::CFG_DIM_W-1:0];
        pdpp_pkg::REG_SOURCE_HEIGHT: height_q <= cfg_data_i[pdpp_pkg::CFG_DIM_W-1:0];
        pdpp_pkg::REG_SAMPLE_SHIFT:  shift_q  <= cfg_data_i[pdpp_pkg::CFG_SHIFT_W-1:0];
        pdpp_pkg::REG_BYTE_ORDER:    order_q  <= cfg_data_i[0];
      endcase
    end
  end

  // effective frame size and factor
  logic [DW-1:0]                    w_eff, h_eff;
  logic [pdpp_pkg::CFG_SHIFT_W-1:0] sh_eff;

  always_comb begin
    if (width_q == '0) begin
      w_eff = DW'(1);
    end else if (CMPW'(width_q) > CMPW'(MAX_DIMENSION)) begin
      w_eff = DW'(MAX_DIMENSION);
    end else begin
      w_eff = DW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = DW'(1);
    end else if (CMPW'(height_q) > CMPW'(MAX_DIMENSION)) begin
      h_eff = DW'(MAX_DIMENSION);
    end else begin
      h_eff = DW'(height_q);
    end
  end

  assign sh_eff = (shift_q == pdpp_pkg::SHIFT_RSVD) ? pdpp_pkg::SHIFT_X4 : shift_q;

  // handshake
  pdpp_pkg::sel_t sel;
  logic           s1_valid_q, out_valid_q;
  logic           out_free, s1_leave, in_ready, in_fire;

  assign out_free = !out_valid_q || out_px.ready;
  assign s1_leave = !sel.keep || out_free;
  assign in_ready = !s1_valid_q || s1_leave;
  assign in_fire  = in_px.valid && in_ready;
  assign in_px.ready = in_ready;

  // position counters
  logic [CW-1:0] col, row;
  logic          last_col, last_row;

  pdpp_pos_counter #(
    .CW (CW),
    .DW (DW)
  ) u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (in_fire),
    .width_i    (w_eff),
    .height_i   (h_eff),
    .col_o      (col),
    .row_o      (row),
    .last_col_o (last_col),
    .last_row_o (last_row)
  );

  // input stage
  logic [7:0]    s1_red_q, s1_green_q, s1_blue_q, s1_alpha_q;
  logic [CW-1:0] s1_col_q, s1_row_q;
  logic          s1_last_col_q, s1_last_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_px.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_red_q      <= in_px.red;
      s1_green_q    <= in_px.green;
      s1_blue_q     <= in_px.blue;
      s1_alpha_q    <= in_px.alpha;
      s1_col_q      <= col;
      s1_row_q      <= row;
      s1_last_col_q <= last_col;
      s1_last_row_q <= last_row;
    end
  end

  // grid selection and pixel formatting
  logic [31:0] word;

  pdpp_sample_select #(
    .CW (CW),
    .DW (DW)
  ) u_sel (
    .col_i      (s1_col_q),
    .row_i      (s1_row_q),
    .last_col_i (s1_last_col_q),
    .last_row_i (s1_last_row_q),
    .width_i    (w_eff),
    .height_i   (h_eff),
    .shift_i    (sh_eff),
    .sel_o      (sel)
  );

  pdpp_premul_pack u_pack (
    .red_i      (s1_red_q),
    .green_i    (s1_green_q),
    .blue_i     (s1_blue_q),
    .alpha_i    (s1_alpha_q),
    .decimate_i (sh_eff != pdpp_pkg::SHIFT_X1),
    .order_i    (order_q),
    .word_o     (word)
  );

  // output register
  logic [31:0] out_word_q;
  logic        out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q && sel.keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q && sel.keep) begin
      out_word_q <= word;
      out_done_q <= sel.frame_done;
    end
  end

  assign out_px.valid      = out_valid_q;
  assign out_px.pixel_word = out_word_q;
  assign out_px.frame_done = out_done_q;

endmodule

@@ rtl/core/pdpp_checker.sv @@
// ----------------------------------------------------------------------------
// pdpp_checker
// Port-level checks of the pixel decimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "pixel_decimate_premultiply_pack_top_macros.svh"

module pdpp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // a waiting pixel beat stays offered
  `PDPP_ASSERT(a_in_hold, in_valid_i && !in_ready_i |=> in_valid_i)

  // a stalled result beat stays offered
  `PDPP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)

  // an empty output register never backs up the input
  `PDPP_ASSERT(a_ready_when_empty, !out_valid_i |-> in_ready_i)

  // input backpressure only comes from a stalled result beat
  `PDPP_ASSERT(a_stall_cause, !in_ready_i |-> out_valid_i && !out_ready_i)

endmodule

bind pixel_decimate_premultiply_pack_top pdpp_checker u_pdpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_px.valid),
  .in_ready_i  (in_px.ready),
  .out_valid_i (out_px.valid),
  .out_ready_i (out_px.ready)
);

@@ sim/pixel_decimate_premultiply_pack_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_decimate_premultiply_pack_top_tb
// Streams RGBA pixels through the decimator under several frame formats and
// handshake idle patterns. A shadow model of the format registers and the
// column/row counters predicts every kept word, which the output monitor
// checks in order.
// ----------------------------------------------------------------------------
module pixel_decimate_premultiply_pack_top_tb;

  localparam int unsigned MAX_DIM       = 4096;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned PHASE_PIXELS  = 320;

  typedef struct packed {
    logic [31:0] word;
    logic        frame_done;
  } px_word_t;

  logic                            clk_i      = 1'b0;
  logic                            rst_ni     = 1'b0;
  logic                            cfg_we_i   = 1'b0;
  logic [pdpp_pkg::CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [pdpp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  pdpp_pixel_if  pix_if ();
  pdpp_result_if res_if ();

  pixel_decimate_premultiply_pack_top #(
    .MAX_DIMENSION(MAX_DIM)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_px     (pix_if),
    .out_px    (res_if)
  );

  // shadow format registers and raster position
  logic [pdpp_pkg::CFG_DIM_W-1:0]   fmt_width  = 13'd1;
  logic [pdpp_pkg::CFG_DIM_W-1:0]   fmt_height = 13'd1;
  logic [pdpp_pkg::CFG_SHIFT_W-1:0] fmt_shift  = pdpp_pkg::SHIFT_X1;
  logic                             fmt_order  = pdpp_pkg::ORDER_RED_LOW;
  int unsigned                      col_pos    = 0;
  int unsigned                      row_pos    = 0;

  px_word_t    expected_px[$];
  int unsigned errors         = 0;
  int unsigned pixels_in      = 0;
  int unsigned words_out      = 0;
  int unsigned frame_ends     = 0;
  int unsigned formats        = 0;
  int unsigned stall_cycles   = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // zero means one, oversize saturates
  function automatic int unsigned effective_dim(input logic [pdpp_pkg::CFG_DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  // rounded c * a / 255 with the product kept to 16 bits
  function automatic logic [7:0] scale_by_alpha(input logic [7:0] c, input logic [7:0] a);
    int unsigned p;
    p = (c * a + 128) & 'hFFFF;
    return 8'((p + (p >> 8)) >> 8);
  endfunction

  // predicts the word for one pixel and advances the raster position
  function automatic logic predict_pixel(input logic [7:0] r, g, b, a,
                                         output px_word_t res);
    int unsigned w, h, sh, f, half, wo, ho;
    logic        last_col, last_row, keep;
    logic [7:0]  rs, gs, bs;
    w        = effective_dim(fmt_width);
    h        = effective_dim(fmt_height);
    sh       = 32'((fmt_shift == pdpp_pkg::SHIFT_RSVD) ? pdpp_pkg::SHIFT_X4 : fmt_shift);
    f        = 1 << sh;
    half     = f >> 1;
    wo       = w >> sh;
    ho       = h >> sh;
    last_col = (col_pos + 1) >= w;
    last_row = (row_pos + 1) >= h;
    res      = '0;
    if (sh == pdpp_pkg::SHIFT_X1) begin
      res.word       = {a, b, g, r};
      res.frame_done = last_col && last_row;
      keep           = 1'b1;
    end else begin
      keep = wo != 0 && ho != 0 && (row_pos & (f - 1)) == 0 && (row_pos >> sh) < ho
             && col_pos >= half && ((col_pos - half) & (f - 1)) == 0
             && ((col_pos - half) >> sh) < wo;
      if (keep) begin
        rs = r;
        gs = g;
        bs = b;
        if (a != pdpp_pkg::ALPHA_OPAQUE) begin
          rs = scale_by_alpha(r, a);
          gs = scale_by_alpha(g, a);
          bs = scale_by_alpha(b, a);
        end
        if (fmt_order == pdpp_pkg::ORDER_ALPHA_LOW)
          res.word = {rs, gs, bs, a};
        else
          res.word = {a, bs, gs, rs};
        res.frame_done = ((row_pos >> sh) == ho - 1) && (((col_pos - half) >> sh) == wo - 1);
      end
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((row_pos + 1) & 'hFFF);
    end else begin
      col_pos = (col_pos + 1) & 'hFFF;
    end
    return keep;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    $display("mismatch on %s at output word %0d: expected %08h, got %08h",
             what, words_out, want, got);
  endtask

  // output checker and input predictor, sampled at the rising edge
  always @(posedge clk_i) begin : monitor
    px_word_t got;
    px_word_t want;
    px_word_t pred;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got.word       = res_if.pixel_word;
        got.frame_done = res_if.frame_done;
        words_out++;
        if (got.frame_done) frame_ends++;
        if (expected_px.size() == 0) begin
          report_mismatch("unexpected beat", '0, got.word);
        end else begin
          want = expected_px.pop_front();
          if (got.word !== want.word)
            report_mismatch("pixel_word", want.word, got.word);
          if (got.frame_done !== want.frame_done)
            report_mismatch("frame_done", 32'(want.frame_done), 32'(got.frame_done));
        end
      end
      if (pix_if.valid && pix_if.ready) begin
        pixels_in++;
        if (predict_pixel(pix_if.red, pix_if.green, pix_if.blue, pix_if.alpha, pred))
          expected_px.push_back(pred);
      end
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || cfg_we_i)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("no beat for %0d cycles", STALL_LIMIT);
    $display("** pixel_decimate_premultiply_pack_top: FAILED **");
    $finish;
  end

  // one pixel beat, entered and left at a falling edge
  task automatic send_pixel(input logic [7:0] r, g, b, a);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= r;
    pix_if.green <= g;
    pix_if.blue  <= b;
    pix_if.alpha <= a;
    do @(posedge clk_i); while (!pix_if.ready);
    @(negedge clk_i);
  endtask

  // random colors, alpha leaning toward opaque and fully clear
  task automatic send_random_pixel();
    logic [7:0] a;
    case ($urandom_range(9))
      0, 1:    a = pdpp_pkg::ALPHA_OPAQUE;
      2:       a = 8'd0;
      default: a = 8'($urandom_range(255));
    endcase
    send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)), a);
  endtask

  // stop sending and let the pipe run empty
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (expected_px.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // writes all four registers while the block is idle
  task automatic set_format(input int unsigned width, height,
                            input logic [pdpp_pkg::CFG_SHIFT_W-1:0] shift,
                            input logic order);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= pdpp_pkg::REG_SOURCE_WIDTH;
    cfg_data_i <= pdpp_pkg::CFG_DATA_W'(width);
    @(negedge clk_i);
    cfg_idx_i  <= pdpp_pkg::REG_SOURCE_HEIGHT;
    cfg_data_i <= pdpp_pkg::CFG_DATA_W'(height);
    @(negedge clk_i);
    cfg_idx_i  <= pdpp_pkg::REG_SAMPLE_SHIFT;
    cfg_data_i <= pdpp_pkg::CFG_DATA_W'(shift);
    @(negedge clk_i);
    cfg_idx_i  <= pdpp_pkg::REG_BYTE_ORDER;
    cfg_data_i <= pdpp_pkg::CFG_DATA_W'(order);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    fmt_width  = pdpp_pkg::CFG_DIM_W'(width);
    fmt_height = pdpp_pkg::CFG_DIM_W'(height);
    fmt_shift  = shift;
    fmt_order  = order;
    formats++;
  endtask

  // registers at reset: 1x1 frame, every pixel ends it
  task automatic test_reset_format();
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // factor one: no premultiply, byte order register ignored
  task automatic test_pass_through();
    int i;
    set_format(3, 2, pdpp_pkg::SHIFT_X1, pdpp_pkg::ORDER_ALPHA_LOW);
    for (i = 0; i < 6; i++) send_pixel(8'(i * 51), 8'hA5, 8'h5A, 8'(i * 40));
  endtask

  // factor two with alpha clear, minimal, near opaque and opaque, both orders
  task automatic test_premultiply();
    logic [7:0] alpha_tab [4];
    int         i;
    int         o;
    alpha_tab = '{8'd0, 8'd1, 8'd254, pdpp_pkg::ALPHA_OPAQUE};
    for (o = 0; o < 2; o++) begin
      set_format(4, 2, pdpp_pkg::SHIFT_X2, 1'(o));
      for (i = 0; i < 8; i++)
        send_pixel(8'hFF, 8'(i * 36), 8'h80, alpha_tab[(i + o) % 4]);
    end
  endtask

  // reserved shift code acts as factor four
  task automatic test_reserved_shift();
    set_format(4, 4, pdpp_pkg::SHIFT_RSVD, pdpp_pkg::ORDER_RED_LOW);
    repeat (16) send_random_pixel();
  endtask

  // zero sizes act as one; too narrow a frame keeps nothing
  task automatic test_degenerate_sizes();
    set_format(0, 0, pdpp_pkg::SHIFT_X1, pdpp_pkg::ORDER_RED_LOW);
    repeat (2) send_random_pixel();
    set_format(3, 4, pdpp_pkg::SHIFT_X4, pdpp_pkg::ORDER_ALPHA_LOW);
    repeat (4) send_random_pixel();
  endtask

  // shrink the frame mid-way so the counters sit past the new end
  task automatic test_counter_wrap();
    set_format(6, 6, pdpp_pkg::SHIFT_X1, pdpp_pkg::ORDER_RED_LOW);
    repeat (9) send_random_pixel();
    set_format(2, 3, pdpp_pkg::SHIFT_X1, pdpp_pkg::ORDER_RED_LOW);
    repeat (4) send_random_pixel();
  endtask

  // oversize width and height saturate instead of wrapping to a small size
  task automatic test_max_dimension();
    set_format(1, 1, pdpp_pkg::SHIFT_X1, pdpp_pkg::ORDER_RED_LOW);
    send_random_pixel();
    set_format(4100, 1, pdpp_pkg::SHIFT_X1, pdpp_pkg::ORDER_RED_LOW);
    repeat (8) send_random_pixel();
    set_format(1, 4098, pdpp_pkg::SHIFT_X1, pdpp_pkg::ORDER_ALPHA_LOW);
    repeat (8) send_random_pixel();
    set_format(8191, 8191, pdpp_pkg::SHIFT_X2, pdpp_pkg::ORDER_ALPHA_LOW);
    repeat (16) send_random_pixel();
  endtask

  // random small formats, mostly whole frames, some cut short
  task automatic test_random_frames(input int unsigned idle_pct, stall_pct);
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned frame;
    int unsigned count;
    int unsigned sel;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    sent           = 0;
    while (sent < PHASE_PIXELS) begin
      sel = $urandom_range(99);
      w   = (sel < 5) ? 0 : (sel < 90) ? $urandom_range(16, 1) : $urandom_range(64, 17);
      h   = ($urandom_range(99) < 5) ? 0 : $urandom_range(8, 1);
      set_format(w, h, pdpp_pkg::CFG_SHIFT_W'($urandom_range(3)), 1'($urandom_range(1)));
      frame = effective_dim(pdpp_pkg::CFG_DIM_W'(w)) * effective_dim(pdpp_pkg::CFG_DIM_W'(h));
      count = ($urandom_range(3) != 0) ? frame * $urandom_range(2, 1)
                                       : $urandom_range(2 * frame + 2, 1);
      repeat (count) send_random_pixel();
      sent += count;
    end
  endtask

  initial begin : run
    pix_if.valid = 1'b0;
    pix_if.red   = '0;
    pix_if.green = '0;
    pix_if.blue  = '0;
    pix_if.alpha = '0;
    res_if.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_format();
    test_pass_through();
    test_premultiply();
    test_reserved_shift();
    test_degenerate_sizes();
    test_counter_wrap();
    test_max_dimension();
    test_random_frames(0, 0);
    test_random_frames(55, 0);
    test_random_frames(0, 55);
    test_random_frames(32, 32);
    wait_idle();

    $display("covered %0d pixels in, %0d words out, %0d frame ends over %0d formats",
             pixels_in, words_out, frame_ends, formats);
    $display("factors 1/2/4 and reserved, both byte orders, empty and saturated sizes");
    if (errors == 0) begin
      $display("** pixel_decimate_premultiply_pack_top: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** pixel_decimate_premultiply_pack_top: FAILED **");
    end
    $finish;
  end

endmodule
